>>> design/packed_field_unpacker_top_assert.svh
// Assertion macros used by the unpacker back end (puf_back).
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef PACKED_FIELD_UNPACKER_TOP_ASSERT_SVH
`define PACKED_FIELD_UNPACKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PUF_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PUF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/puf_pkg.sv
// Package for the packed field unpacker: constants, register codes, config struct.
// No dependencies.
package puf_pkg;

    localparam int WORD_BITS   = 32;
    localparam int ACC_BITS    = 2 * WORD_BITS - 1;   // held bits plus one word
    localparam int HELD_BITS   = 5;                   // leftover bits 0..31
    localparam int AVAIL_BITS  = 6;                   // accumulator fill 0..63
    localparam int WIDTH_BITS  = 6;
    localparam int ROWS_BITS   = 16;
    localparam int STRIDE_BITS = 8;
    localparam int INDEX_BITS  = 24;
    localparam int NRES_BITS   = 5;                   // results per word, 0..31 done
    localparam int CFG_IDX_BITS = 2;

    // Register reset values
    localparam logic [WIDTH_BITS-1:0]  FIELD_WIDTH_RST = 6'd8;
    localparam logic [ROWS_BITS-1:0]   ROW_COUNT_RST   = 16'd1;
    localparam logic [STRIDE_BITS-1:0] COL_STRIDE_RST  = 8'd1;
    localparam logic [WORD_BITS-1:0]   OFFSET_RST      = 32'd0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIELD_WIDTH  = 2'd0,
        CFG_ROW_COUNT    = 2'd1,
        CFG_COL_STRIDE   = 2'd2,
        CFG_VALUE_OFFSET = 2'd3
    } cfg_reg_t;

    // Effective configuration, already clamped to legal ranges
    typedef struct packed {
        logic [WIDTH_BITS-1:0]  width;    // 1..32
        logic [ROWS_BITS-1:0]   rows;     // 1..65535
        logic [STRIDE_BITS-1:0] stride;
        logic [WORD_BITS-1:0]   offset;
    } cfg_t;

endpackage

>>> design/puf_if.sv
// Stream interfaces for the unpacker: packed words in, results out.
// Depends on puf_pkg.
interface puf_word_if;
    import puf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] packed_word;

    modport source (output valid, output packed_word, input ready);
    modport sink   (input valid, input packed_word, output ready);
endinterface

interface puf_result_if;
    import puf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] value;
    logic [INDEX_BITS-1:0]       dest_index;
    logic                        last_of_word;
    logic                        last_of_column;

    modport source (output valid, output value, output dest_index,
                    output last_of_word, output last_of_column, input ready);
    modport sink   (input valid, input value, input dest_index,
                    input last_of_word, input last_of_column, output ready);
endinterface

>>> design/puf_front.sv
// Front end: configuration registers with range clamping, and the input item register.
// Depends on puf_pkg and puf_word_if.
module puf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [puf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [puf_pkg::WORD_BITS-1:0] cfg_data,
    puf_word_if.sink                      words,
    output puf_pkg::cfg_t                 cfg,
    output logic                          push_valid,
    output logic [puf_pkg::WORD_BITS-1:0] push_word,
    input  logic                          push_ready
);
    import puf_pkg::*;

    logic [WIDTH_BITS-1:0]  field_width_reg;
    logic [ROWS_BITS-1:0]   row_count_reg;
    logic [STRIDE_BITS-1:0] col_stride_reg;
    logic [WORD_BITS-1:0]   offset_reg;
    logic                   valid_reg, valid_next;
    logic [WORD_BITS-1:0]   word_reg;
    logic                   accept;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg <= FIELD_WIDTH_RST;
            row_count_reg   <= ROW_COUNT_RST;
            col_stride_reg  <= COL_STRIDE_RST;
            offset_reg      <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIELD_WIDTH:  field_width_reg <= cfg_data[WIDTH_BITS-1:0];
                CFG_ROW_COUNT:    row_count_reg   <= cfg_data[ROWS_BITS-1:0];
                CFG_COL_STRIDE:   col_stride_reg  <= cfg_data[STRIDE_BITS-1:0];
                CFG_VALUE_OFFSET: offset_reg      <= cfg_data;
            endcase
        end
    end

    // Clamp: width 0 acts as 1, above 32 as 32; row count 0 acts as 1
    always_comb
    begin
        if (field_width_reg == '0)
            cfg.width = WIDTH_BITS'(1);
        else if (field_width_reg > WIDTH_BITS'(WORD_BITS))
            cfg.width = WIDTH_BITS'(WORD_BITS);
        else
            cfg.width = field_width_reg;
        cfg.rows   = (row_count_reg == '0) ? ROWS_BITS'(1) : row_count_reg;
        cfg.stride = col_stride_reg;
        cfg.offset = offset_reg;
    end

    // Input register: takes an item whenever it is empty or draining into the queue
    assign words.ready = !valid_reg || push_ready;
    assign accept      = words.valid && words.ready;
    assign valid_next  = accept ? 1'b1 : (push_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= words.packed_word;
    end

    assign push_valid = valid_reg;
    assign push_word  = word_reg;

endmodule

>>> design/puf_queue.sv
// Short word queue between front and back end, register storage.
// Depends on puf_pkg.
module puf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push_valid,
    input  logic [puf_pkg::WORD_BITS-1:0] push_word,
    output logic                          push_ready,
    output logic                          pop_valid,
    output logic [puf_pkg::WORD_BITS-1:0] pop_word,
    input  logic                          pop
);
    import puf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WORD_BITS-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = count_reg < CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

>>> design/puf_back.sv
// Back end: bit accumulator, one field per unstalled cycle, column counters, result register.
// Depends on puf_pkg, puf_result_if and the assertion macro header.
module puf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  puf_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  logic [puf_pkg::WORD_BITS-1:0] q_word,
    output logic                          q_pop,
    puf_result_if.source                  results
);
    import puf_pkg::*;

    `include "packed_field_unpacker_top_assert.svh"

    // Accumulator is right aligned: live bits are acc_reg[avail_reg-1:0]
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [AVAIL_BITS-1:0]  avail_reg, avail_next;
    logic                   busy_reg, busy_next;
    logic [NRES_BITS-1:0]   n_reg, n_next;
    logic [ROWS_BITS-1:0]   values_done_reg, values_done_next;
    logic [INDEX_BITS-1:0]  next_index_reg, next_index_next;

    logic                   out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]   out_value_reg;
    logic [INDEX_BITS-1:0]  out_index_reg;
    logic                   out_word_reg, out_col_reg;

    logic                   out_free, emit, last, col_end, take_word;
    logic [AVAIL_BITS-1:0]  rem_avail, avail_after;
    logic [ACC_BITS-1:0]    shifted;
    logic [WORD_BITS-1:0]   field_mask, field;

    // Field extraction from the top of the live bits
    assign rem_avail  = avail_reg - cfg.width;
    assign shifted    = acc_reg >> rem_avail;
    assign field_mask = {WORD_BITS{1'b1}} >> (WIDTH_BITS'(WORD_BITS) - cfg.width);
    assign field      = shifted[WORD_BITS-1:0] & field_mask;

    // End tests for the column and for the current word
    assign col_end = ({1'b0, values_done_reg} + (ROWS_BITS + 1)'(1)) >= {1'b0, cfg.rows};
    assign last    = col_end || (n_reg == NRES_BITS'(WORD_BITS - 1)) || (rem_avail < cfg.width);

    assign out_free  = !out_valid_reg || results.ready;
    assign emit      = busy_reg && out_free;
    assign take_word = q_valid && (!busy_reg || (emit && last));
    assign q_pop     = take_word;

    // Fill left after this cycle, before any new word is shifted in
    always_comb
    begin
        if (emit)
            avail_after = col_end ? '0 : rem_avail;
        else
            avail_after = avail_reg;
    end

    // Extraction state update
    always_comb
    begin
        acc_next         = acc_reg;
        avail_next       = avail_after;
        busy_next        = busy_reg;
        n_next           = n_reg;
        values_done_next = values_done_reg;
        next_index_next  = next_index_reg;
        if (emit)
        begin
            n_next = last ? '0 : n_reg + 1'b1;
            if (col_end)
            begin
                values_done_next = '0;
                next_index_next  = '0;
            end
            else
            begin
                values_done_next = values_done_reg + 1'b1;
                next_index_next  = next_index_reg + INDEX_BITS'(cfg.stride);
            end
            if (last)
                busy_next = 1'b0;
        end
        if (take_word)
        begin
            acc_next   = {acc_reg[WORD_BITS-2:0], q_word};
            avail_next = {1'b1, avail_after[HELD_BITS-1:0]};
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg       <= '0;
            busy_reg        <= 1'b0;
            n_reg           <= '0;
            values_done_reg <= '0;
            next_index_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            avail_reg       <= avail_next;
            busy_reg        <= busy_next;
            n_reg           <= n_next;
            values_done_reg <= values_done_next;
            next_index_reg  <= next_index_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Result register
    assign out_valid_next = emit ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= field + cfg.offset;
            out_index_reg <= next_index_reg;
            out_word_reg  <= last;
            out_col_reg   <= col_end;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.value          = $signed(out_value_reg);
    assign results.dest_index     = out_index_reg;
    assign results.last_of_word   = out_word_reg;
    assign results.last_of_column = out_col_reg;

    `PUF_ASSERT(a_idle_leftover, !busy_reg, avail_reg < AVAIL_BITS'(WORD_BITS), "leftover bits exceed 31 while idle")
    `PUF_ASSERT(a_busy_has_field, busy_reg, avail_reg >= cfg.width, "busy without a whole field held")
    `PUF_ASSERT_NEXT(a_col_clears, emit && col_end, values_done_reg == '0 && next_index_reg == '0, "column end did not clear counters")
    `PUF_ASSERT(a_col_ends_word, out_valid_reg && out_col_reg, out_word_reg, "column end not flagged as end of word")

endmodule

>>> design/packed_field_unpacker_top.sv
// Channel    | Dir | Payload                                         | Handshake
// words      | in  | packed_word[31:0]                               | valid/ready
// results    | out | value[31:0] s, dest_index[23:0], last_of_word,  | valid/ready
//            |     | last_of_column                                  |
// cfg        | in  | cfg_index[1:0], cfg_data[31:0]                  | cfg_we, no wait
//
// One result per cycle from the field extractor unless results stall; a word yields up to 32/field_width
// results (plus one when leftover bits complete a field).
// Words enter at one per cycle into the input register and queue while the extractor runs, until the queue is full.
// Reset clears all control state and the column counters; no clearing pass is needed.
// A stall on results holds the result register; the queue keeps taking words until full.
//
// Top level of the packed field unpacker. Depends on puf_pkg, the interfaces,
// puf_front, puf_queue and puf_back.
module packed_field_unpacker_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [puf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [puf_pkg::WORD_BITS-1:0]    cfg_data,
    puf_word_if.sink                         words,
    puf_result_if.source                     results
);
    import puf_pkg::*;

    cfg_t                 cfg;
    logic                 push_valid, push_ready;
    logic [WORD_BITS-1:0] push_word;
    logic                 q_valid, q_pop;
    logic [WORD_BITS-1:0] q_word;

    // Accept words and hold configuration
    puf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .words      (words),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_word  (push_word),
        .push_ready (push_ready)
    );

    // Decouple front and back
    puf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_word   (q_word),
        .pop        (q_pop)
    );

    // Extract fields
    puf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule
